@@ rtl/scvs_pkg.sv @@
// Shared types and codes for the second chance victim selector.
package scvs_pkg;

  localparam int IDX_W = 6;
  localparam int OP_W  = 2;

  localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OP_W-1:0] OP_VICTIM = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [IDX_W-1:0] frame_index;
    logic             is_write;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] victim_index;
    logic             victim_found;
    logic             victim_dirty;
    logic             op_ok;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic accessed;
    logic dirty;
  } slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

@@ rtl/scvs_mem.sv @@
// Slot state memory: one write port, one registered read port.
module scvs_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output scvs_pkg::slot_t  rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  scvs_pkg::slot_t  wr_data
);
  import scvs_pkg::*;

  slot_t mem_r [DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/scvs_ctrl.sv @@
// Sequencer: clearing pass, read-modify-write of single slots, victim scan.
module scvs_ctrl #(
  parameter int NUM_FRAMES = 64,
  parameter int AW         = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scvs_pkg::in_item_t  in_data,
  output logic                res_valid,
  input  logic                res_ready,
  output scvs_pkg::out_item_t res_data,
  output logic                mem_rd_en,
  output logic [AW-1:0]       mem_rd_addr,
  input  scvs_pkg::slot_t     mem_rd_data,
  output logic                mem_wr_en,
  output logic [AW-1:0]       mem_wr_addr,
  output scvs_pkg::slot_t     mem_wr_data
);
  import scvs_pkg::*;

  localparam int XW = (AW + 1 > IDX_W) ? AW + 1 : IDX_W;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   cnt_r;
  logic            cnt_last;
  logic [OP_W-1:0] op_r;
  logic [AW-1:0]   idx_r;
  logic            wr_r;
  logic            rng_r;
  logic            pend_r;
  logic [AW-1:0]   pend_idx_r;
  logic            have_r, cdirty_r, pick_dirty_r, any_r, last_dirty_r;
  logic [AW-1:0]   pick_r, last_r;

  logic [XW-1:0]   in_idx_x;
  logic            in_rng;
  logic [AW-1:0]   in_addr;
  logic            in_accept;
  logic            sel_found, sel_dirty;
  logic [AW-1:0]   sel_idx;

  assign in_idx_x  = XW'(in_data.frame_index);
  assign in_rng    = in_idx_x < XW'(NUM_FRAMES);
  assign in_addr   = in_idx_x[AW-1:0];
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cnt_last  = (cnt_r == AW'(NUM_FRAMES - 1));

  assign sel_found = have_r || any_r;
  assign sel_idx   = have_r ? pick_r : last_r;
  assign sel_dirty = have_r ? pick_dirty_r : last_dirty_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (cnt_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (in_data.operation == OP_VICTIM) ? ST_SCAN : ST_OP;
        end
      end
      ST_OP:   if (res_ready) state_nxt = ST_IDLE;
      ST_SCAN: if (cnt_last) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_DONE;
      ST_DONE: if (res_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = cnt_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cnt_r;
    mem_wr_data = '0;
    res_valid   = 1'b0;
    res_data    = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      ST_IDLE: begin
        mem_rd_en   = in_accept;
        mem_rd_addr = in_addr;
      end
      ST_OP: begin
        mem_wr_addr = idx_r;
        if (res_ready) begin
          res_valid = 1'b1;
          case (op_r)
            OP_ACCESS: begin
              if (rng_r && mem_rd_data.valid) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '{valid: 1'b1, accessed: 1'b1,
                                dirty: mem_rd_data.dirty | wr_r};
                res_data.op_ok = 1'b1;
              end
            end
            OP_INSERT: begin
              if (rng_r && !mem_rd_data.valid) begin
                mem_wr_en   = 1'b1;
                mem_wr_data = '{valid: 1'b1, accessed: 1'b0, dirty: 1'b0};
                res_data.op_ok = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (rng_r) begin
                mem_wr_en      = 1'b1;
                res_data.op_ok = 1'b1;
              end
            end
            default: res_data.op_ok = 1'b0;
          endcase
        end
      end
      ST_SCAN, ST_EVAL: begin
        mem_rd_en   = (state_r == ST_SCAN);
        mem_wr_addr = pend_idx_r;
        if (pend_r && mem_rd_data.valid && mem_rd_data.accessed) begin
          mem_wr_en   = 1'b1;
          mem_wr_data = '{valid: 1'b1, accessed: 1'b0, dirty: mem_rd_data.dirty};
        end
      end
      ST_DONE: begin
        mem_wr_addr = sel_idx;
        if (res_ready) begin
          res_valid             = 1'b1;
          res_data.op_ok        = 1'b1;
          res_data.victim_found = sel_found;
          if (sel_found) begin
            res_data.victim_index = IDX_W'(sel_idx);
            res_data.victim_dirty = sel_dirty;
            mem_wr_en   = 1'b1;
            mem_wr_data = '{valid: 1'b1, accessed: 1'b0, dirty: 1'b0};
          end
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN);
      if (state_r == ST_CLEAR || state_r == ST_SCAN) begin
        cnt_r <= cnt_r + AW'(1);
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= cnt_r;
    if (in_accept) begin
      op_r     <= in_data.operation;
      idx_r    <= in_addr;
      wr_r     <= in_data.is_write;
      rng_r    <= in_rng;
      have_r   <= 1'b0;
      any_r    <= 1'b0;
      cdirty_r <= 1'b1;
    end else if (pend_r && mem_rd_data.valid) begin
      any_r        <= 1'b1;
      last_r       <= pend_idx_r;
      last_dirty_r <= mem_rd_data.dirty;
      if (!mem_rd_data.accessed) begin
        cdirty_r     <= 1'b0;
        have_r       <= 1'b1;
        pick_r       <= pend_idx_r;
        pick_dirty_r <= mem_rd_data.dirty;
      end else if (cdirty_r && !mem_rd_data.dirty) begin
        cdirty_r     <= 1'b0;
        have_r       <= 1'b1;
        pick_r       <= pend_idx_r;
        pick_dirty_r <= 1'b0;
      end
    end
  end

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
    else $error("read and write hit the same slot");

  a_res_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_ready && (state_r == ST_OP || state_r == ST_DONE))
    else $error("result issued without room");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_OP || state_r == ST_SCAN)
    else $error("accepted transfer did not start work");

  a_scan_reaches_eval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && cnt_last |=> state_r == ST_EVAL && pend_r)
    else $error("scan did not finish with the last slot pending");

endmodule

@@ rtl/second_chance_victim_selector_top.sv @@
// Top level of the second chance victim selector with the result register.
//
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_stall, in_data    | in
//  result  | out_valid, out_stall, out_data | out
//
// Access, insert and remove read the slot, then write it back.
// A victim request scans one slot per cycle through
// the single read port of the slot memory.
// After reset a clearing pass over all NUM_FRAMES slots holds in_stall high.
// The result register holds a transfer under out_stall; the next item is
// taken meanwhile and waits at its write-back step until the register frees.
module second_chance_victim_selector_top #(
  parameter int NUM_FRAMES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  scvs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output scvs_pkg::out_item_t out_data
);
  import scvs_pkg::*;

  localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  logic          res_valid, res_ready;
  out_item_t     res_data;
  logic          out_valid_r;
  out_item_t     out_data_r;
  logic          mem_rd_en, mem_wr_en;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  slot_t         mem_rd_data, mem_wr_data;

  assign res_ready = !out_valid_r || !out_stall;

  scvs_ctrl #(.NUM_FRAMES(NUM_FRAMES), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data)
  );

  scvs_mem #(.DEPTH(NUM_FRAMES), .AW(AW)) u_mem (
    .clk    (clk),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/second_chance_victim_selector_top_test.sv @@
// Testbench for the second chance victim selector with a built-in frame table predictor.
`timescale 1ns / 1ps

module second_chance_victim_selector_top_test;
  import scvs_pkg::*;

  localparam int NUM_FRAMES  = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  bit [NUM_FRAMES-1:0] frame_live;
  bit [NUM_FRAMES-1:0] frame_ref;
  bit [NUM_FRAMES-1:0] frame_mod;

  out_item_t outcomes_due[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_request = 0;
  int        stall_left = 0;

  second_chance_victim_selector_top #(.NUM_FRAMES(NUM_FRAMES)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("second_chance_victim_selector_top verification failed");
      $finish;
    end
  end

  function automatic int idle_span(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic out_item_t frame_table_step(in_item_t item);
    out_item_t res;
    bit        have;
    bit        pick_dirty;
    bit        any;
    int        pick;
    int        last;
    int        idx;
    res = '0;
    idx = item.frame_index;
    if (item.operation == OP_VICTIM) begin
      have = 1'b0;
      pick_dirty = 1'b1;
      any = 1'b0;
      pick = 0;
      last = 0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (frame_live[i]) begin
          any = 1'b1;
          last = i;
          if (frame_ref[i]) begin
            frame_ref[i] = 1'b0;
            if (pick_dirty && !frame_mod[i]) begin
              pick_dirty = 1'b0;
              pick = i;
              have = 1'b1;
            end
          end else begin
            pick_dirty = 1'b0;
            pick = i;
            have = 1'b1;
          end
        end
      end
      if (!have && any) begin
        pick = last;
        have = 1'b1;
      end
      res.op_ok = 1'b1;
      if (have) begin
        res.victim_found = 1'b1;
        res.victim_index = IDX_W'(pick);
        res.victim_dirty = frame_mod[pick];
        frame_ref[pick] = 1'b0;
        frame_mod[pick] = 1'b0;
      end
    end else if (idx < NUM_FRAMES) begin
      case (item.operation)
        OP_ACCESS: begin
          if (frame_live[idx]) begin
            frame_ref[idx] = 1'b1;
            if (item.is_write) frame_mod[idx] = 1'b1;
            res.op_ok = 1'b1;
          end
        end
        OP_INSERT: begin
          if (!frame_live[idx]) begin
            frame_live[idx] = 1'b1;
            frame_ref[idx] = 1'b0;
            frame_mod[idx] = 1'b0;
            res.op_ok = 1'b1;
          end
        end
        default: begin
          frame_live[idx] = 1'b0;
          frame_ref[idx] = 1'b0;
          frame_mod[idx] = 1'b0;
          res.op_ok = 1'b1;
        end
      endcase
    end
    return res;
  endfunction

  function automatic in_item_t frame_op(logic [OP_W-1:0] op, int idx, bit wr);
    in_item_t item;
    item.operation = op;
    item.frame_index = IDX_W'(idx);
    item.is_write = wr;
    return item;
  endfunction

  function automatic in_item_t random_frame_op(int span, int victim_pct);
    in_item_t item;
    int       roll;
    roll = $urandom_range(0, 99);
    item = frame_op(OP_ACCESS, $urandom_range(0, span - 1), 1'($urandom_range(0, 1)));
    if (roll < 8) begin
      item = in_item_t'(9'($urandom_range(0, 511)));
    end else if (roll < 8 + victim_pct) begin
      item.operation = OP_VICTIM;
      item.frame_index = IDX_W'($urandom_range(0, 63));
    end else if (roll < 55 + victim_pct) begin
      for (int k = 0; k < 8 && !frame_live[item.frame_index]; k++)
        item.frame_index = IDX_W'($urandom_range(0, span - 1));
    end else if (roll < 80 + victim_pct / 2) begin
      item.operation = OP_INSERT;
    end else begin
      item.operation = OP_REMOVE;
    end
    return item;
  endfunction

  task automatic send_frame_op(input in_item_t item);
    int gap;
    gap = idle_span(tx_idle_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    outcomes_due.push_back(frame_table_step(item));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outcomes_due.size() > 0) @(posedge clk);
  endtask

  task automatic report_field(string name, int want, int got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (stall_left == 0) begin
        stall_left = idle_span(rx_idle_pct);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (outcomes_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = outcomes_due.pop_front();
        if (out_data.victim_index !== want.victim_index)
          report_field("victim_index", want.victim_index, out_data.victim_index);
        if (out_data.victim_found !== want.victim_found)
          report_field("victim_found", want.victim_found, out_data.victim_found);
        if (out_data.victim_dirty !== want.victim_dirty)
          report_field("victim_dirty", want.victim_dirty, out_data.victim_dirty);
        if (out_data.op_ok !== want.op_ok)
          report_field("op_ok", want.op_ok, out_data.op_ok);
      end
    end
  end

  task automatic test_directed();
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_frame_op(frame_op(OP_VICTIM, 63, 1'b1));
    send_frame_op(frame_op(OP_ACCESS, 5, 1'b1));
    send_frame_op(frame_op(OP_REMOVE, 7, 1'b0));
    send_frame_op(frame_op(OP_INSERT, 0, 1'b0));
    send_frame_op(frame_op(OP_INSERT, 63, 1'b1));
    send_frame_op(frame_op(OP_INSERT, 0, 1'b1));
    send_frame_op(frame_op(OP_ACCESS, 0, 1'b1));
    send_frame_op(frame_op(OP_ACCESS, 63, 1'b0));
    send_frame_op(frame_op(OP_VICTIM, 0, 1'b0));
    send_frame_op(frame_op(OP_VICTIM, 21, 1'b1));
    send_frame_op(frame_op(OP_ACCESS, 0, 1'b1));
    send_frame_op(frame_op(OP_ACCESS, 63, 1'b1));
    send_frame_op(frame_op(OP_VICTIM, 42, 1'b0));
    send_frame_op(frame_op(OP_INSERT, 42, 1'b1));
    send_frame_op(frame_op(OP_ACCESS, 42, 1'b0));
    send_frame_op(frame_op(OP_ACCESS, 0, 1'b0));
    send_frame_op(frame_op(OP_VICTIM, 63, 1'b0));
    send_frame_op(frame_op(OP_REMOVE, 63, 1'b1));
    send_frame_op(frame_op(OP_REMOVE, 63, 1'b0));
    send_frame_op(frame_op(OP_ACCESS, 63, 1'b1));
    send_frame_op(frame_op(OP_VICTIM, 0, 1'b1));
    send_frame_op(frame_op(OP_REMOVE, 0, 1'b0));
    send_frame_op(frame_op(OP_REMOVE, 42, 1'b1));
    send_frame_op(frame_op(OP_VICTIM, 63, 1'b0));
    wait_drained();
  endtask

  task automatic test_back_to_back();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (50) send_frame_op(random_frame_op(8, 15));
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 300;
    repeat (30) send_frame_op(random_frame_op(16, 20));
    wait_drained();
    rx_idle_pct = 30;
    tx_idle_pct = 30;
    repeat (10) send_frame_op(random_frame_op(16, 20));
    wait_drained();
  endtask

  task automatic test_random_mix();
    tx_idle_pct = 35;
    rx_idle_pct = 35;
    repeat (100) send_frame_op(random_frame_op(64, 10));
    repeat (80) send_frame_op(random_frame_op(8, 20));
    wait_drained();
    repeat (60) send_frame_op(random_frame_op(3, 25));
    tx_idle_pct = 10;
    rx_idle_pct = 50;
    repeat (60) send_frame_op(random_frame_op(64, 30));
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_backpressure();
    test_random_mix();
    repeat (NUM_FRAMES + 8) @(posedge clk);
    if (mismatches == 0 && outcomes_due.size() == 0) begin
      $display("second_chance_victim_selector_top verification clean");
    end else begin
      $display("second_chance_victim_selector_top verification failed");
    end
    $finish;
  end

endmodule
